/* rtl/core/pfp_pkg.sv */
// Shared types and constants for the pixel format packer.
// No dependencies; used by every file in rtl/core.
package pfp_pkg;

	localparam int unsigned PIX_W    = 32;
	localparam int unsigned DEPTH_W  = 6;
	localparam int unsigned CWIDTH_W = 4;
	localparam int unsigned SHIFT_W  = 5;
	localparam int unsigned PADDR_W  = 5;
	localparam int unsigned PDATA_W  = 32;
	localparam int unsigned CHAN_MAX = 8;

	// v*(2^w-1)+127 stays below 2^23 for w up to 15
	localparam int unsigned SUM_W    = 23;
	localparam int unsigned SCALED_W = 15;
	localparam int unsigned RECIP_W  = 24;
	localparam int unsigned RECIP_SH = 31;
	// ceil(2^31 / 255): exact quotient for sums below 2^31 / 127
	localparam logic [RECIP_W-1:0] RECIP_255 = 24'd8421505;
	localparam logic [SUM_W-1:0]   ROUND_ADD = 23'd127;

	typedef enum logic [2:0] {
		REG_DEPTH   = 3'd0,
		REG_R_WIDTH = 3'd1,
		REG_R_SHIFT = 3'd2,
		REG_G_WIDTH = 3'd3,
		REG_G_SHIFT = 3'd4,
		REG_B_WIDTH = 3'd5,
		REG_B_SHIFT = 3'd6
	} reg_idx_t;

	localparam logic [DEPTH_W-1:0]  DEPTH_RST   = 6'd32;
	localparam logic [CWIDTH_W-1:0] WIDTH_RST   = 4'd8;
	localparam logic [SHIFT_W-1:0]  R_SHIFT_RST = 5'd16;
	localparam logic [SHIFT_W-1:0]  G_SHIFT_RST = 5'd8;
	localparam logic [SHIFT_W-1:0]  B_SHIFT_RST = 5'd0;

	localparam logic [DEPTH_W-1:0] DEPTH_8  = 6'd8;
	localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
	localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;

	typedef struct packed {
		logic [CWIDTH_W-1:0] width;
		logic [SHIFT_W-1:0]  shift;
	} chan_cfg_t;

endpackage

/* rtl/core/pfp_if.sv */
// Stream interfaces for the pixel format packer: source pixels in, packed pixels out.
// Depends on pfp_pkg.
interface pfp_pix_if;
	logic                        valid;
	logic                        ready;
	logic [pfp_pkg::PIX_W-1:0]   source_pixel;

	modport source (output valid, output source_pixel, input ready);
	modport sink   (input valid, input source_pixel, output ready);
endinterface

interface pfp_out_if;
	logic                        valid;
	logic                        ready;
	logic [pfp_pkg::PIX_W-1:0]   packed_pixel;
	logic                        format_ok;

	modport source (output valid, output packed_pixel, output format_ok, input ready);
	modport sink   (input valid, input packed_pixel, input format_ok, output ready);
endinterface

/* rtl/core/pfp_chan.sv */
// One color channel: scale an 8-bit value to the configured width with rounding,
// then place it at the configured bit position. Depends on pfp_pkg.
module pfp_chan (
	input  logic [7:0]                  value,
	input  pfp_pkg::chan_cfg_t          cfg,
	output logic [pfp_pkg::PIX_W-1:0]   placed
);

	logic [pfp_pkg::SUM_W-1:0]                     sum;
	logic [pfp_pkg::SUM_W+pfp_pkg::RECIP_W-1:0]    prod;
	logic [pfp_pkg::SCALED_W-1:0]                  scaled;

	// v*(2^w-1) as shift and subtract, plus rounding term
	assign sum = (pfp_pkg::SUM_W'(value) << cfg.width) - pfp_pkg::SUM_W'(value)
	             + pfp_pkg::ROUND_ADD;

	// divide by 255 through the reciprocal
	assign prod   = (pfp_pkg::SUM_W+pfp_pkg::RECIP_W)'(sum)
	              * (pfp_pkg::SUM_W+pfp_pkg::RECIP_W)'(pfp_pkg::RECIP_255);
	assign scaled = prod[pfp_pkg::RECIP_SH +: pfp_pkg::SCALED_W];

	assign placed = pfp_pkg::PIX_W'(scaled) << cfg.shift;

endmodule

/* rtl/core/pfp_fmt_check.sv */
// Format validity: depth, per-channel fit within the depth, and mask overlap.
// Depends on pfp_pkg.
module pfp_fmt_check (
	input  logic [pfp_pkg::DEPTH_W-1:0]  depth,
	input  pfp_pkg::chan_cfg_t [2:0]     chans,
	output logic                         ok
);

	localparam int unsigned MASK_W = pfp_pkg::PIX_W + pfp_pkg::CHAN_MAX;

	logic [2:0]        fit;
	logic [MASK_W-1:0] mask [3];
	logic              depth_ok;
	logic              overlap;

	assign depth_ok = (depth == pfp_pkg::DEPTH_8) || (depth == pfp_pkg::DEPTH_16)
	               || (depth == pfp_pkg::DEPTH_32);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fit[i] = (chans[i].width != '0)
			      && (chans[i].width <= pfp_pkg::CWIDTH_W'(pfp_pkg::CHAN_MAX))
			      && (pfp_pkg::DEPTH_W'(chans[i].shift) < depth)
			      && (pfp_pkg::DEPTH_W'(chans[i].width)
			          <= depth - pfp_pkg::DEPTH_W'(chans[i].shift));
			mask[i] = ((MASK_W'(1) << chans[i].width) - MASK_W'(1)) << chans[i].shift;
		end
	end

	assign overlap = ((mask[0] & mask[1]) != '0) || ((mask[0] & mask[2]) != '0)
	              || ((mask[1] & mask[2]) != '0);

	assign ok = depth_ok && (&fit) && !overlap;

endmodule

/* rtl/core/pixel_format_packer.sv */
// Top level of the pixel format packer: APB register file, input register,
// three channel scalers and result register. Depends on pfp_pkg, pfp_if,
// pfp_chan and pfp_fmt_check.
//
// Converts one XRGB8888 pixel per transfer into a packed framebuffer pixel.
// Each of red, green and blue is scaled from 8 bits to its configured width
// with rounding, (v*(2^w-1)+127)/255, shifted to its configured position and
// ORed into a 32-bit word; bits pushed past bit 31 are lost. format_ok flags
// whether the programmed format is legal (depth 8, 16 or 32, each width 1..8
// fitting inside the depth, no overlapping channels); the pixel is packed the
// same way either way. The block takes one pixel every clock cycle while the
// output is not stalled; a pixel passes through the input register, then the
// result register behind the per-channel divide-by-255 reciprocal multiply,
// which sets the cycle time. Both stages hold under back-pressure and the
// input keeps accepting while a result waits, as long as a stage is free.
// Registers sit at byte address 4*index on the APB port, writes take effect
// on the access cycle, pready is tied high. Reprogram only while no pixel
// is in flight.
module pixel_format_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfp_pkg::PADDR_W-1:0]   paddr,
	input  logic [pfp_pkg::PDATA_W-1:0]   pwdata,
	output logic [pfp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	pfp_pix_if.sink                       pix_in,
	pfp_out_if.source                     pix_out
);

	// configuration registers
	logic [pfp_pkg::DEPTH_W-1:0] depth_q;
	pfp_pkg::chan_cfg_t          red_q;
	pfp_pkg::chan_cfg_t          green_q;
	pfp_pkg::chan_cfg_t          blue_q;

	logic                     cfg_wr;
	pfp_pkg::reg_idx_t        cfg_idx;

	// pipeline
	logic                        valid_s1;
	logic [23:0]                 rgb_s1;
	logic                        valid_s2;
	logic [pfp_pkg::PIX_W-1:0]   packed_s2;
	logic                        ok_s2;
	logic                        load_s1;
	logic                        load_s2;

	logic [pfp_pkg::PIX_W-1:0]   red_px;
	logic [pfp_pkg::PIX_W-1:0]   green_px;
	logic [pfp_pkg::PIX_W-1:0]   blue_px;
	logic                        fmt_ok;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = pfp_pkg::reg_idx_t'(paddr[pfp_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q       <= pfp_pkg::DEPTH_RST;
			red_q.width   <= pfp_pkg::WIDTH_RST;
			red_q.shift   <= pfp_pkg::R_SHIFT_RST;
			green_q.width <= pfp_pkg::WIDTH_RST;
			green_q.shift <= pfp_pkg::G_SHIFT_RST;
			blue_q.width  <= pfp_pkg::WIDTH_RST;
			blue_q.shift  <= pfp_pkg::B_SHIFT_RST;
		end else if (cfg_wr) begin
			// mask to register width; unknown index drops the write
			case (cfg_idx)
				pfp_pkg::REG_DEPTH:   depth_q       <= pwdata[pfp_pkg::DEPTH_W-1:0];
				pfp_pkg::REG_R_WIDTH: red_q.width   <= pwdata[pfp_pkg::CWIDTH_W-1:0];
				pfp_pkg::REG_R_SHIFT: red_q.shift   <= pwdata[pfp_pkg::SHIFT_W-1:0];
				pfp_pkg::REG_G_WIDTH: green_q.width <= pwdata[pfp_pkg::CWIDTH_W-1:0];
				pfp_pkg::REG_G_SHIFT: green_q.shift <= pwdata[pfp_pkg::SHIFT_W-1:0];
				pfp_pkg::REG_B_WIDTH: blue_q.width  <= pwdata[pfp_pkg::CWIDTH_W-1:0];
				pfp_pkg::REG_B_SHIFT: blue_q.shift  <= pwdata[pfp_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pfp_pkg::REG_DEPTH:   prdata = pfp_pkg::PDATA_W'(depth_q);
			pfp_pkg::REG_R_WIDTH: prdata = pfp_pkg::PDATA_W'(red_q.width);
			pfp_pkg::REG_R_SHIFT: prdata = pfp_pkg::PDATA_W'(red_q.shift);
			pfp_pkg::REG_G_WIDTH: prdata = pfp_pkg::PDATA_W'(green_q.width);
			pfp_pkg::REG_G_SHIFT: prdata = pfp_pkg::PDATA_W'(green_q.shift);
			pfp_pkg::REG_B_WIDTH: prdata = pfp_pkg::PDATA_W'(blue_q.width);
			pfp_pkg::REG_B_SHIFT: prdata = pfp_pkg::PDATA_W'(blue_q.shift);
			default:              prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- handshake
	// advance a stage when it is empty or the stage behind drains
	assign load_s2      = !valid_s2 || pix_out.ready;
	assign load_s1      = !valid_s1 || load_s2;
	assign pix_in.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= pix_in.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// drop the unused top byte at the input register
	always_ff @(posedge clk) begin
		if (load_s1 && pix_in.valid) begin
			rgb_s1 <= pix_in.source_pixel[23:0];
		end
	end

	// ------------------------------------------------------------ datapath
	pfp_chan u_red (
		.value  (rgb_s1[23:16]),
		.cfg    (red_q),
		.placed (red_px)
	);

	pfp_chan u_green (
		.value  (rgb_s1[15:8]),
		.cfg    (green_q),
		.placed (green_px)
	);

	pfp_chan u_blue (
		.value  (rgb_s1[7:0]),
		.cfg    (blue_q),
		.placed (blue_px)
	);

	pfp_fmt_check u_fmt (
		.depth (depth_q),
		.chans ({blue_q, green_q, red_q}),
		.ok    (fmt_ok)
	);

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			packed_s2 <= red_px | green_px | blue_px;
			ok_s2     <= fmt_ok;
		end
	end

	assign pix_out.valid        = valid_s2;
	assign pix_out.packed_pixel = packed_s2;
	assign pix_out.format_ok    = ok_s2;

endmodule

/* bench/pixel_format_packer_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for pixel_format_packer: a scoreboard class predicts every packed pixel
// and format_ok flag from the programmed registers. Depends on pfp_pkg, pfp_if and the RTL.
package packer_check_pkg;
	import pfp_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             ok;
	} packed_result_t;

	class packed_pixel_scoreboard;
		logic [DEPTH_W-1:0] depth;
		chan_cfg_t          red;
		chan_cfg_t          green;
		chan_cfg_t          blue;
		packed_result_t     outstanding[$];
		int unsigned        mismatches;
		int unsigned        checked;
		int unsigned        legal_seen;

		function new();
			depth       = DEPTH_RST;
			red.width   = WIDTH_RST;
			red.shift   = R_SHIFT_RST;
			green.width = WIDTH_RST;
			green.shift = G_SHIFT_RST;
			blue.width  = WIDTH_RST;
			blue.shift  = B_SHIFT_RST;
			mismatches  = 0;
			checked     = 0;
			legal_seen  = 0;
		endfunction

		// Mirror an APB write; unmapped addresses fall through untouched.
		function void write_reg(int unsigned idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_DEPTH:   depth       = value[DEPTH_W-1:0];
				REG_R_WIDTH: red.width   = value[CWIDTH_W-1:0];
				REG_R_SHIFT: red.shift   = value[SHIFT_W-1:0];
				REG_G_WIDTH: green.width = value[CWIDTH_W-1:0];
				REG_G_SHIFT: green.shift = value[SHIFT_W-1:0];
				REG_B_WIDTH: blue.width  = value[CWIDTH_W-1:0];
				REG_B_SHIFT: blue.shift  = value[SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [SCALED_W-1:0] round_scale(logic [7:0] v, logic [CWIDTH_W-1:0] w);
			logic [15:0]    top;
			logic [SUM_W-1:0] sum;
			top = (16'd1 << w) - 16'd1;
			sum = SUM_W'(v) * SUM_W'(top) + SUM_W'(127);
			return SCALED_W'(sum / SUM_W'(255));
		endfunction

		function logic [PIX_W-1:0] place_channel(logic [7:0] v, chan_cfg_t c);
			logic [PIX_W-1:0] wide;
			wide = PIX_W'(round_scale(v, c.width));
			return wide << c.shift;
		endfunction

		function bit channel_fits(chan_cfg_t c);
			int w;
			int s;
			int d;
			w = c.width;
			s = c.shift;
			d = depth;
			return w > 0 && w <= int'(CHAN_MAX) && s < d && w <= d - s;
		endfunction

		function logic [39:0] channel_bits(chan_cfg_t c);
			return ((40'd1 << c.width) - 40'd1) << c.shift;
		endfunction

		function bit format_legal();
			logic [39:0] mr;
			logic [39:0] mg;
			logic [39:0] mb;
			if (depth != DEPTH_8 && depth != DEPTH_16 && depth != DEPTH_32)
				return 1'b0;
			if (!channel_fits(red) || !channel_fits(green) || !channel_fits(blue))
				return 1'b0;
			mr = channel_bits(red);
			mg = channel_bits(green);
			mb = channel_bits(blue);
			return (mr & mg) == 0 && (mr & mb) == 0 && (mg & mb) == 0;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] px);
			packed_result_t e;
			e.pixel = place_channel(px[23:16], red) | place_channel(px[15:8], green) |
				place_channel(px[7:0], blue);
			e.ok = format_legal();
			outstanding.push_back(e);
		endfunction

		function void check_result(logic [PIX_W-1:0] pixel, logic ok);
			packed_result_t e;
			if (outstanding.size() == 0) begin
				$error("packed_pixel 0x%h arrived with no source pixel outstanding", pixel);
				mismatches++;
				return;
			end
			e = outstanding.pop_front();
			checked++;
			if (e.ok)
				legal_seen++;
			if (pixel !== e.pixel) begin
				$error("packed_pixel: expected 0x%h, got 0x%h", e.pixel, pixel);
				mismatches++;
			end
			if (ok !== e.ok) begin
				$error("format_ok: expected %b, got %b", e.ok, ok);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return outstanding.size();
		endfunction
	endclass
endpackage

module pixel_format_packer_tb;
	import pfp_pkg::*;
	import packer_check_pkg::*;

	localparam int unsigned NUM_REGS      = 7;
	localparam int unsigned UNMAPPED_REG  = NUM_REGS;   // first address past the register file
	localparam int unsigned REG_STRIDE    = 4;
	localparam int unsigned RANDOM_ITEMS  = 750;
	localparam int unsigned HOLD_CYCLES   = 160;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	localparam logic [PIX_W-1:0] CORNER_PIXELS [8] = '{
		32'h0000_0000, 32'hffff_ffff, 32'hff00_0000, 32'h00ff_0000,
		32'h0000_ff00, 32'h0000_00ff, 32'h0080_8080, 32'h007f_7f7f
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pfp_pix_if pix_in ();
	pfp_out_if pix_out ();

	pixel_format_packer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	packed_pixel_scoreboard sb = new();

	// Idle control shared by both sides: no_idle forces back-to-back transfers,
	// hold_request asks the receiver for one long stall on its next result.
	bit          no_idle;
	int unsigned hold_request;
	int unsigned settings_total;
	int unsigned settings_legal;
	int unsigned cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic chan_cfg_t chan(int unsigned w, int unsigned s);
		chan_cfg_t c;
		c.width = CWIDTH_W'(w);
		c.shift = SHIFT_W'(s);
		return c;
	endfunction

	// Bias each color byte toward 0x00, 0xff, 0x7f or 0x80 now and then; the top byte stays random.
	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] px;
		px = $urandom();
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0:       px[8*k +: 8] = 8'h00;
					1:       px[8*k +: 8] = 8'hff;
					2:       px[8*k +: 8] = 8'h7f;
					default: px[8*k +: 8] = 8'h80;
				endcase
			end
		end
		return px;
	endfunction

	// Setup phase at one falling edge, access phase at the next; the register
	// takes the value at the rising edge that sees pready.
	task automatic apb_write(int unsigned idx, logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * REG_STRIDE);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write all seven registers starting at a random one, sometimes with junk
	// above each field, and now and then poke the unmapped address as well.
	task automatic program_format(logic [DEPTH_W-1:0] d, chan_cfg_t r, chan_cfg_t g,
		chan_cfg_t b);
		logic [PDATA_W-1:0] fields [NUM_REGS];
		int unsigned        widths [NUM_REGS];
		logic [PDATA_W-1:0] value;
		int unsigned        start;
		int unsigned        idx;
		fields[REG_DEPTH]   = PDATA_W'(d);
		fields[REG_R_WIDTH] = PDATA_W'(r.width);
		fields[REG_R_SHIFT] = PDATA_W'(r.shift);
		fields[REG_G_WIDTH] = PDATA_W'(g.width);
		fields[REG_G_SHIFT] = PDATA_W'(g.shift);
		fields[REG_B_WIDTH] = PDATA_W'(b.width);
		fields[REG_B_SHIFT] = PDATA_W'(b.shift);
		widths[REG_DEPTH]   = DEPTH_W;
		widths[REG_R_WIDTH] = CWIDTH_W;
		widths[REG_R_SHIFT] = SHIFT_W;
		widths[REG_G_WIDTH] = CWIDTH_W;
		widths[REG_G_SHIFT] = SHIFT_W;
		widths[REG_B_WIDTH] = CWIDTH_W;
		widths[REG_B_SHIFT] = SHIFT_W;
		start = $urandom_range(0, NUM_REGS - 1);
		for (int k = 0; k < NUM_REGS; k++) begin
			idx   = (start + k) % NUM_REGS;
			value = fields[idx];
			if ($urandom_range(0, 1))
				value = value | ($urandom() << widths[idx]);
			apb_write(idx, value);
		end
		if ($urandom_range(0, 3) == 0)
			apb_write(UNMAPPED_REG, $urandom());
		settings_total++;
		if (sb.format_legal())
			settings_legal++;
	endtask

	// Offer one pixel after a drawn gap; hold valid and data until the transfer.
	task automatic send_pixel(logic [PIX_W-1:0] px);
		int unsigned gap;
		gap = idle_cycles();
		@(negedge clk);
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid        <= 1'b1;
		pix_in.source_pixel <= px;
		do @(posedge clk); while (!pix_in.ready);
		sb.note_pixel(px);
	endtask

	task automatic run_pixels(int unsigned count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// Drop valid and wait until every predicted result has been checked.
	task automatic drain_stream();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic directed_format(logic [DEPTH_W-1:0] d, chan_cfg_t r, chan_cfg_t g,
		chan_cfg_t b);
		program_format(d, r, g, b);
		send_pixel(32'hffff_ffff);
		send_pixel(random_pixel());
		drain_stream();
	endtask

	// Mostly legal layouts packed into a random depth, then broken or fully
	// random ones so format_ok and the raw packing both get exercised.
	task automatic program_random_format();
		logic [DEPTH_W-1:0] d;
		chan_cfg_t          ch [3];
		int unsigned        w [3];
		int unsigned        order [3];
		int unsigned        kind;
		int unsigned        k;
		int unsigned        j;
		int unsigned        tmp;
		int unsigned        free_bits;
		int unsigned        pos;
		int unsigned        step;
		case ($urandom_range(0, 2))
			0:       d = DEPTH_8;
			1:       d = DEPTH_16;
			default: d = DEPTH_32;
		endcase
		for (int n = 0; n < 3; n++) begin
			w[n]     = $urandom_range(1, CHAN_MAX);
			order[n] = n;
		end
		while (w[0] + w[1] + w[2] > d) begin
			k = $urandom_range(0, 2);
			if (w[k] > 1)
				w[k]--;
		end
		for (int n = 2; n > 0; n--) begin
			j        = $urandom_range(0, n);
			tmp      = order[n];
			order[n] = order[j];
			order[j] = tmp;
		end
		free_bits = d - (w[0] + w[1] + w[2]);
		pos       = $urandom_range(0, free_bits);
		free_bits = free_bits - pos;
		for (int n = 0; n < 3; n++) begin
			ch[order[n]] = chan(w[order[n]], pos);
			pos          = pos + w[order[n]];
			step         = $urandom_range(0, free_bits);
			pos          = pos + step;
			free_bits    = free_bits - step;
		end
		kind = $urandom_range(0, 19);
		k    = $urandom_range(0, 2);
		if (kind >= 17) begin
			d = DEPTH_W'($urandom_range(0, 63));
			for (int n = 0; n < 3; n++)
				ch[n] = chan($urandom_range(0, 15), $urandom_range(0, 31));
		end else if (kind >= 12) begin
			case ($urandom_range(0, 4))
				0: d = DEPTH_W'($urandom_range(0, 63));
				1: ch[k].width = $urandom_range(0, 1) ? CWIDTH_W'(0) :
					CWIDTH_W'($urandom_range(9, 15));
				2: ch[k].shift = ch[(k + 1) % 3].shift;
				3: ch[k].shift = SHIFT_W'($urandom_range(0, 31));
				default: ch[k].width = CWIDTH_W'($urandom_range(0, 15));
			endcase
		end
		program_format(d, ch[0], ch[1], ch[2]);
	endtask

	// Receiver: stall a drawn number of cycles before each result, or the long
	// hold-off when one is requested, then take the transfer and check it.
	initial begin
		int unsigned stall;
		pix_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request != 0) begin
				stall        = hold_request;
				hold_request = 0;
			end else begin
				stall = idle_cycles();
			end
			@(negedge clk);
			if (stall != 0) begin
				pix_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!pix_out.valid);
			sb.check_result(pix_out.packed_pixel, pix_out.format_ok);
		end
	end

	// Watchdog: count cycles and abort the run if it never finishes.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("cycle limit of %0d reached with %0d results outstanding", CYCLE_LIMIT,
			sb.pending());
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned random_left;
		int unsigned count;
		int unsigned phase;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		pix_in.valid        = 1'b0;
		pix_in.source_pixel = '0;
		no_idle             = 1'b0;
		hold_request        = 0;
		settings_total      = 1;
		settings_legal      = sb.format_legal() ? 1 : 0;

		// Hold reset low, then release it on a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Corner pixels through the reset format (plain XRGB8888 passthrough).
		foreach (CORNER_PIXELS[n])
			send_pixel(CORNER_PIXELS[n]);
		drain_stream();

		// Legal 16-bit and 8-bit layouts with rounding to 5, 6, 3 and 2 bits.
		directed_format(DEPTH_16, chan(5, 11), chan(6, 5), chan(5, 0));
		directed_format(DEPTH_8, chan(3, 5), chan(3, 2), chan(2, 0));
		// Zero-width red: contributes nothing and fails the format check.
		directed_format(DEPTH_32, chan(0, 16), chan(8, 8), chan(8, 0));
		// Widths above eight, with blue pushed past bit 31.
		directed_format(DEPTH_32, chan(15, 20), chan(9, 0), chan(12, 28));
		// Every register at its top value, then every register at zero.
		directed_format(DEPTH_W'(63), chan(15, 31), chan(15, 31), chan(15, 31));
		directed_format(DEPTH_W'(0), chan(0, 0), chan(0, 0), chan(0, 0));
		// Green overlaps red by one bit.
		directed_format(DEPTH_16, chan(5, 11), chan(6, 6), chan(5, 0));

		// Random phases: a new format each time, drained before reprogramming.
		random_left = RANDOM_ITEMS;
		phase       = 0;
		while (random_left > 0) begin
			count = $urandom_range(20, 42);
			if (count > random_left)
				count = random_left;
			program_random_format();
			no_idle = (phase % 5 == 2);
			if (phase == 3) begin
				// Stall the output for a long stretch while the input keeps
				// offering back to back, so the pipeline fills and blocks.
				no_idle      = 1'b1;
				hold_request = HOLD_CYCLES;
			end
			if (phase == 8) begin
				// Pause the source mid-burst until the output has caught up.
				run_pixels(count / 2);
				drain_stream();
				run_pixels(count - count / 2);
			end else begin
				run_pixels(count);
			end
			drain_stream();
			random_left = random_left - count;
			phase++;
		end
		no_idle = 1'b0;

		// Give any stray result time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Packed %0d pixels under %0d register settings, %0d of them legal formats.",
			sb.checked, settings_total, settings_legal);
		$display("Included a %0d-cycle output stall and a source pause mid-burst.",
			HOLD_CYCLES);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
